>>> hdl/gwwlb_pkg.sv
package gwwlb_pkg;

   localparam int CHAR_BITS  = 16;
   localparam int ADV_BITS   = 8;
   localparam int WID_BITS   = 17;
   localparam int LINE_BITS  = 24;
   localparam int CSR_BITS   = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int MAX_RECS   = 3;
   localparam int CNT_BITS   = 2;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   localparam logic [CHAR_BITS-1:0] CH_NEWLINE  = 16'h000A;
   localparam logic [CHAR_BITS-1:0] CH_SPACE    = 16'h0020;
   localparam logic [CHAR_BITS-1:0] CH_TAB      = 16'h0009;
   localparam logic [CHAR_BITS-1:0] CH_VTAB     = 16'h000B;
   localparam logic [CHAR_BITS-1:0] CH_FORMFEED = 16'h000C;
   localparam logic [CHAR_BITS-1:0] CH_HYPHEN   = 16'h002D;
   localparam logic [CHAR_BITS-1:0] CH_IDEO_SP  = 16'h3000;
   localparam logic [CHAR_BITS-1:0] CH_NBSP     = 16'h00A0;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_MAX_LINE_WIDTH = 3'd0,
      CSR_CHAR_GAP       = 3'd1,
      CSR_WRAP_WORDS     = 3'd2,
      CSR_INDENT_ENABLE  = 3'd3,
      CSR_INDENT_WIDTH   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0] max_line_width;
      logic [7:0]  char_gap;
      logic        wrap_words;
      logic        indent_enable;
      logic [9:0]  indent_width;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      max_line_width: 16'd640,
      char_gap:       8'd0,
      wrap_words:     1'b1,
      indent_enable:  1'b0,
      indent_width:   10'd0
   };

   typedef struct packed {
      logic [LINE_BITS-1:0] line_start;
      logic [LINE_BITS-1:0] line_length;
      logic                 line_indent;
   } rec_type;

   // All line records caused by one character, in emission order from slot 0.
   typedef struct packed {
      logic [CNT_BITS-1:0]       count;
      rec_type [MAX_RECS-1:0]    recs;
   } bundle_type;

   function automatic logic plain_space(logic [CHAR_BITS-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FORMFEED);
   endfunction

   function automatic logic indent_space(logic [CHAR_BITS-1:0] c);
      return plain_space(c) || (c == CH_IDEO_SP) || (c == CH_NBSP) || (c == CH_NEWLINE);
   endfunction

   function automatic logic [WID_BITS-1:0] sat_add(logic [WID_BITS-1:0] a,
                                                   logic [WID_BITS-1:0] b);
      logic [WID_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WID_BITS] ? {WID_BITS{1'b1}} : s[WID_BITS-1:0];
   endfunction

endpackage

>>> hdl/gwwlb_front.sv
module gwwlb_front #(
   parameter int POS_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gwwlb_pkg::cfg_type              cfg,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gwwlb_pkg::CHAR_BITS-1:0] req_char_code,
   input  logic [gwwlb_pkg::ADV_BITS-1:0]  req_char_advance,
   input  logic                            req_text_last,
   input  logic                            q_full,
   output logic                            push_valid,
   output gwwlb_pkg::bundle_type           push_data
);
   import gwwlb_pkg::*;

   logic [POS_BITS-1:0] text_pos_ff, text_pos_in;
   logic [POS_BITS-1:0] cur_start_ff, cur_start_in;
   logic [POS_BITS-1:0] cur_length_ff, cur_length_in;
   logic [POS_BITS-1:0] word_begin_ff, word_begin_in;
   logic [WID_BITS-1:0] cur_width_ff, cur_width_in;
   logic [WID_BITS-1:0] word_pixels_ff, word_pixels_in;
   logic                cur_indent_ff, cur_indent_in;
   logic                swallow_ff, swallow_in;
   logic                after_nl_ff, after_nl_in;

   logic                accept;
   logic [WID_BITS-1:0] adv;
   logic [WID_BITS-1:0] max_w;
   logic [WID_BITS-1:0] width1;
   logic [POS_BITS-1:0] p;
   logic [POS_BITS-1:0] keep;
   logic                brk;
   logic                indent0;
   logic [CNT_BITS-1:0] n;
   bundle_type          bnd;

   function automatic rec_type mk_rec(logic [POS_BITS-1:0] s, logic [POS_BITS-1:0] l,
                                      logic ind);
      rec_type r;
      r.line_start  = LINE_BITS'(s);
      r.line_length = LINE_BITS'(l);
      r.line_indent = ind;
      return r;
   endfunction

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign push_valid = accept && (n != '0);
   assign push_data  = bnd;

   assign adv   = WID_BITS'(req_char_advance) + WID_BITS'(cfg.char_gap);
   assign max_w = WID_BITS'(cfg.max_line_width);
   assign p     = text_pos_ff;

   always_comb begin
      text_pos_in    = p + 1'b1;
      cur_start_in   = cur_start_ff;
      cur_length_in  = cur_length_ff;
      word_begin_in  = word_begin_ff;
      cur_width_in   = cur_width_ff;
      word_pixels_in = word_pixels_ff;
      swallow_in     = swallow_ff;
      after_nl_in    = 1'b0;
      indent0        = cur_indent_ff;
      width1         = '0;
      keep           = '0;
      brk            = 1'b0;
      n              = '0;
      bnd            = '0;

      // The first character of a paragraph decides its indent.
      if (after_nl_ff && cfg.indent_enable && !indent_space(req_char_code)) begin
         indent0      = 1'b1;
         cur_width_in = sat_add(cur_width_ff, WID_BITS'(cfg.indent_width));
      end
      cur_indent_in = indent0;

      if (req_char_code == CH_NEWLINE) begin
         swallow_in     = 1'b0;
         bnd.recs[n]    = mk_rec(cur_start_ff, cur_length_ff + 1'b1, indent0);
         n              = n + 1'b1;
         cur_start_in   = p + 1'b1;
         cur_length_in  = '0;
         cur_width_in   = '0;
         word_begin_in  = p + 1'b1;
         word_pixels_in = '0;
         cur_indent_in  = 1'b0;
         after_nl_in    = 1'b1;
      end else if (swallow_ff) begin
         if (plain_space(req_char_code)) begin
            cur_length_in = cur_length_ff + 1'b1;
         end else begin
            swallow_in     = 1'b0;
            bnd.recs[n]    = mk_rec(cur_start_ff, cur_length_ff, indent0);
            n              = n + 1'b1;
            cur_start_in   = p;
            cur_length_in  = POS_BITS'(1);
            cur_width_in   = adv;
            word_begin_in  = p;
            word_pixels_in = adv;
            cur_indent_in  = 1'b0;
         end
      end else begin
         brk = plain_space(req_char_code) || (req_char_code == CH_HYPHEN);
         if (brk) begin
            word_begin_in  = p + 1'b1;
            word_pixels_in = '0;
         end else begin
            word_pixels_in = sat_add(word_pixels_ff, adv);
         end
         width1       = sat_add(cur_width_in, adv);
         cur_width_in = width1;
         if (width1 > max_w) begin
            if (!cfg.wrap_words) begin
               bnd.recs[n]   = mk_rec(cur_start_ff, cur_length_ff, indent0);
               n             = n + 1'b1;
               cur_start_in  = p;
               cur_length_in = POS_BITS'(1);
               cur_width_in  = adv;
               cur_indent_in = 1'b0;
               if (!brk) begin
                  word_begin_in  = p;
                  word_pixels_in = adv;
               end
            end else if (plain_space(req_char_code)) begin
               cur_length_in = cur_length_ff + 1'b1;
               swallow_in    = 1'b1;
            end else if (word_begin_in == cur_start_ff) begin
               bnd.recs[n]    = mk_rec(cur_start_ff, cur_length_ff, indent0);
               n              = n + 1'b1;
               cur_start_in   = p;
               cur_length_in  = POS_BITS'(1);
               cur_width_in   = adv;
               word_begin_in  = p;
               word_pixels_in = adv;
               cur_indent_in  = 1'b0;
            end else begin
               // The partial word moves down to a line of its own.
               keep          = p - word_begin_in;
               bnd.recs[n]   = mk_rec(cur_start_ff, cur_length_ff - keep, indent0);
               n             = n + 1'b1;
               cur_start_in  = word_begin_in;
               cur_length_in = keep + 1'b1;
               cur_width_in  = word_pixels_in;
               cur_indent_in = 1'b0;
               if (word_pixels_in > max_w) begin
                  // Still too wide: split it before the current character.
                  bnd.recs[n]    = mk_rec(word_begin_in, keep, 1'b0);
                  n              = n + 1'b1;
                  cur_start_in   = p;
                  cur_length_in  = POS_BITS'(1);
                  cur_width_in   = adv;
                  word_begin_in  = p;
                  word_pixels_in = adv;
               end
            end
         end else begin
            cur_length_in = cur_length_ff + 1'b1;
         end
      end

      if (req_text_last) begin
         if (cur_length_in != '0) begin
            bnd.recs[n] = mk_rec(cur_start_in, cur_length_in, cur_indent_in);
            n           = n + 1'b1;
         end
         text_pos_in    = '0;
         cur_start_in   = '0;
         cur_length_in  = '0;
         word_begin_in  = '0;
         cur_width_in   = '0;
         word_pixels_in = '0;
         cur_indent_in  = 1'b0;
         swallow_in     = 1'b0;
         after_nl_in    = 1'b0;
      end

      bnd.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_pos_ff    <= '0;
         cur_start_ff   <= '0;
         cur_length_ff  <= '0;
         word_begin_ff  <= '0;
         cur_width_ff   <= '0;
         word_pixels_ff <= '0;
         cur_indent_ff  <= 1'b0;
         swallow_ff     <= 1'b0;
         after_nl_ff    <= 1'b0;
      end else if (accept) begin
         text_pos_ff    <= text_pos_in;
         cur_start_ff   <= cur_start_in;
         cur_length_ff  <= cur_length_in;
         word_begin_ff  <= word_begin_in;
         cur_width_ff   <= cur_width_in;
         word_pixels_ff <= word_pixels_in;
         cur_indent_ff  <= cur_indent_in;
         swallow_ff     <= swallow_in;
         after_nl_ff    <= after_nl_in;
      end
   end

endmodule

>>> hdl/gwwlb_queue.sv
module gwwlb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  gwwlb_pkg::bundle_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output gwwlb_pkg::bundle_type head
);
   import gwwlb_pkg::*;

   bundle_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ff, rd_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full    = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ff];
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/gwwlb_back.sv
module gwwlb_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  gwwlb_pkg::bundle_type           q_head,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [gwwlb_pkg::LINE_BITS-1:0] rsp_line_start,
   output logic [gwwlb_pkg::LINE_BITS-1:0] rsp_line_length,
   output logic                            rsp_line_indent,
   output logic                            rsp_run_last
);
   import gwwlb_pkg::*;

   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic                valid_ff, valid_in;
   rec_type             rec_ff, rec_in;
   logic                last_ff, last_in;
   logic                advance;
   logic                head_last;

   // The output register is reloaded whenever it is empty or being taken.
   assign advance   = !valid_ff || !rsp_stall;
   assign head_last = ((idx_ff + 1'b1) == q_head.count);
   assign q_pop     = advance && !q_empty && head_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      rec_in   = rec_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            rec_in  = q_head.recs[idx_ff];
            last_in = head_last;
            idx_in  = head_last ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff  <= rec_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_line_start  = rec_ff.line_start;
   assign rsp_line_length = rec_ff.line_length;
   assign rsp_line_indent = rec_ff.line_indent;
   assign rsp_run_last    = last_ff;

endmodule

>>> hdl/greedy_word_wrap_line_breaker.sv
// Channel   Direction  Handshake          Carries
// req_      in         req_valid/stall    one text character and its advance
// rsp_      out        rsp_valid/stall    one line record (start, length, indent)
// csr_      in         csr_valid/ready    register index and write data
//
// The front end takes one character per cycle while req_stall is low; its line state
// updates in that cycle. The records a character causes (up to three) go into a
// four-entry queue as one group. The back end sends one record per cycle while
// rsp_stall is low, so one character per cycle passes until the output limits it.
// Reset is synchronous: line state clears and registers return to their defaults.
// req_stall rises only while the record queue is full; csr_ready is always high.
module greedy_word_wrap_line_breaker #(
   parameter int POS_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gwwlb_pkg::CHAR_BITS-1:0]     req_char_code,
   input  logic [gwwlb_pkg::ADV_BITS-1:0]      req_char_advance,
   input  logic                                req_text_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gwwlb_pkg::LINE_BITS-1:0]     rsp_line_start,
   output logic [gwwlb_pkg::LINE_BITS-1:0]     rsp_line_length,
   output logic                                rsp_line_indent,
   output logic                                rsp_run_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gwwlb_pkg::CSR_BITS-1:0]      csr_index,
   input  logic [gwwlb_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import gwwlb_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   logic       push_valid;
   bundle_type push_data;
   bundle_type q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_LINE_WIDTH: cfg_in.max_line_width = csr_data;
            CSR_CHAR_GAP:       cfg_in.char_gap       = csr_data[7:0];
            CSR_WRAP_WORDS:     cfg_in.wrap_words     = csr_data[0];
            CSR_INDENT_ENABLE:  cfg_in.indent_enable  = csr_data[0];
            CSR_INDENT_WIDTH:   cfg_in.indent_width   = csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gwwlb_front #(
      .POS_BITS(POS_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_char_advance (req_char_advance),
      .req_text_last    (req_text_last),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_data        (push_data)
   );

   gwwlb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   gwwlb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_line_start  (rsp_line_start),
      .rsp_line_length (rsp_line_length),
      .rsp_line_indent (rsp_line_indent),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

>>> tb/greedy_word_wrap_line_breaker_tb.sv
class line_break_scoreboard;

   typedef bit [gwwlb_pkg::LINE_BITS-1:0] pos_type;
   typedef bit [gwwlb_pkg::WID_BITS-1:0]  width_type;

   typedef struct {
      bit [gwwlb_pkg::LINE_BITS-1:0] start;
      bit [gwwlb_pkg::LINE_BITS-1:0] length;
      bit                            indent;
      bit                            run_last;
   } line_rec_type;

   // Register shadow.
   bit [15:0] max_width;
   bit [7:0]  gap_px;
   bit        wrap_on;
   bit        indent_on;
   bit [9:0]  indent_px;

   // Line state of the predictor.
   bit [gwwlb_pkg::LINE_BITS-1:0] text_pos, cur_start, cur_length, word_begin;
   bit [gwwlb_pkg::WID_BITS-1:0]  cur_width, word_pixels;
   bit                            cur_indent, swallowing, after_newline;

   line_rec_type expected_lines[$];
   int           error_count;

   function new();
      max_width = gwwlb_pkg::CFG_RESET.max_line_width;
      gap_px    = gwwlb_pkg::CFG_RESET.char_gap;
      wrap_on   = gwwlb_pkg::CFG_RESET.wrap_words;
      indent_on = gwwlb_pkg::CFG_RESET.indent_enable;
      indent_px = gwwlb_pkg::CFG_RESET.indent_width;
      error_count = 0;
      clear_text();
   endfunction

   function void clear_text();
      text_pos = '0;
      cur_start = '0;
      cur_length = '0;
      word_begin = '0;
      cur_width = '0;
      word_pixels = '0;
      cur_indent = 1'b0;
      swallowing = 1'b0;
      after_newline = 1'b0;
   endfunction

   function int pending();
      return expected_lines.size();
   endfunction

   function void write_reg(gwwlb_pkg::csr_index_type idx, bit [15:0] data);
      unique case (idx)
         gwwlb_pkg::CSR_MAX_LINE_WIDTH: max_width = data;
         gwwlb_pkg::CSR_CHAR_GAP:       gap_px = data[7:0];
         gwwlb_pkg::CSR_WRAP_WORDS:     wrap_on = data[0];
         gwwlb_pkg::CSR_INDENT_ENABLE:  indent_on = data[0];
         gwwlb_pkg::CSR_INDENT_WIDTH:   indent_px = data[9:0];
         default: ;
      endcase
   endfunction

   function bit is_blank(bit [15:0] c);
      return c == gwwlb_pkg::CH_SPACE || c == gwwlb_pkg::CH_TAB ||
             c == gwwlb_pkg::CH_VTAB || c == gwwlb_pkg::CH_FORMFEED;
   endfunction

   function bit blocks_indent(bit [15:0] c);
      return is_blank(c) || c == gwwlb_pkg::CH_IDEO_SP || c == gwwlb_pkg::CH_NBSP ||
             c == gwwlb_pkg::CH_NEWLINE;
   endfunction

   function bit [gwwlb_pkg::WID_BITS-1:0] width_add(bit [gwwlb_pkg::WID_BITS-1:0] a,
                                                    bit [gwwlb_pkg::WID_BITS-1:0] b);
      bit [gwwlb_pkg::WID_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[gwwlb_pkg::WID_BITS] ? '1 : sum[gwwlb_pkg::WID_BITS-1:0];
   endfunction

   function void add_line(bit [gwwlb_pkg::LINE_BITS-1:0] start,
                          bit [gwwlb_pkg::LINE_BITS-1:0] length, bit indent);
      line_rec_type rec;
      rec.start = start;
      rec.length = length;
      rec.indent = indent;
      rec.run_last = 1'b0;
      expected_lines.push_back(rec);
   endfunction

   function void open_line(bit [gwwlb_pkg::LINE_BITS-1:0] pos,
                           bit [gwwlb_pkg::WID_BITS-1:0] px);
      cur_start = pos;
      cur_length = pos_type'(1);
      cur_width = px;
      word_begin = pos;
      word_pixels = px;
      cur_indent = 1'b0;
   endfunction

   // Works out the line records that one accepted character produces.
   function void note_char(bit [15:0] c, bit [7:0] advance, bit last);
      bit [gwwlb_pkg::WID_BITS-1:0]  adv;
      bit [gwwlb_pkg::LINE_BITS-1:0] p, keep;
      bit                            brk;
      int                            first;
      adv = width_type'(advance) + width_type'(gap_px);
      p = text_pos;
      first = expected_lines.size();

      if (after_newline) begin
         after_newline = 1'b0;
         if (indent_on && !blocks_indent(c)) begin
            cur_indent = 1'b1;
            cur_width = width_add(cur_width, width_type'(indent_px));
         end
      end

      if (c == gwwlb_pkg::CH_NEWLINE) begin
         swallowing = 1'b0;
         add_line(cur_start, cur_length + 1'b1, cur_indent);
         cur_start = p + 1'b1;
         cur_length = '0;
         cur_width = '0;
         word_begin = cur_start;
         word_pixels = '0;
         cur_indent = 1'b0;
         after_newline = 1'b1;
      end else if (swallowing) begin
         if (is_blank(c)) begin
            cur_length = cur_length + 1'b1;
         end else begin
            swallowing = 1'b0;
            add_line(cur_start, cur_length, cur_indent);
            open_line(p, adv);
         end
      end else begin
         brk = is_blank(c) || c == gwwlb_pkg::CH_HYPHEN;
         if (brk) begin
            word_begin = p + 1'b1;
            word_pixels = '0;
         end else begin
            word_pixels = width_add(word_pixels, adv);
         end
         cur_width = width_add(cur_width, adv);
         if (cur_width > max_width) begin
            if (!wrap_on) begin
               add_line(cur_start, cur_length, cur_indent);
               cur_start = p;
               cur_length = pos_type'(1);
               cur_width = adv;
               cur_indent = 1'b0;
               if (!brk) begin
                  word_begin = p;
                  word_pixels = adv;
               end
            end else if (is_blank(c)) begin
               cur_length = cur_length + 1'b1;
               swallowing = 1'b1;
            end else if (word_begin == cur_start) begin
               add_line(cur_start, cur_length, cur_indent);
               open_line(p, adv);
            end else begin
               // The partial word moves down; split it if it still does not fit.
               keep = p - word_begin;
               add_line(cur_start, cur_length - keep, cur_indent);
               cur_start = word_begin;
               cur_length = keep + 1'b1;
               cur_width = word_pixels;
               cur_indent = 1'b0;
               if (cur_width > max_width) begin
                  add_line(cur_start, keep, 1'b0);
                  open_line(p, adv);
               end
            end
         end else begin
            cur_length = cur_length + 1'b1;
         end
      end

      text_pos = p + 1'b1;
      if (last) begin
         if (cur_length != 0)
            add_line(cur_start, cur_length, cur_indent);
         clear_text();
      end
      if (expected_lines.size() > first)
         expected_lines[expected_lines.size() - 1].run_last = 1'b1;
   endfunction

   task report_mismatch(string what);
      error_count++;
      $display("line record mismatch: %s", what);
   endtask

   task check_line(bit [gwwlb_pkg::LINE_BITS-1:0] start, bit [gwwlb_pkg::LINE_BITS-1:0] length,
                   bit indent, bit run_last);
      line_rec_type want;
      if (expected_lines.size() == 0) begin
         report_mismatch($sformatf("unexpected record start %0d length %0d", start, length));
      end else begin
         want = expected_lines.pop_front();
         if (start != want.start)
            report_mismatch($sformatf("line_start %0d, expected %0d", start, want.start));
         if (length != want.length)
            report_mismatch($sformatf("line_length %0d, expected %0d", length, want.length));
         if (indent != want.indent)
            report_mismatch($sformatf("line_indent %0b, expected %0b", indent, want.indent));
         if (run_last != want.run_last)
            report_mismatch($sformatf("run_last %0b, expected %0b", run_last, want.run_last));
      end
   endtask

endclass

module greedy_word_wrap_line_breaker_tb;
   import gwwlb_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 60;
   localparam int ITEMS_PER_PHASE = 10;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CHAR_BITS-1:0]     req_char_code;
   logic [ADV_BITS-1:0]      req_char_advance;
   logic                     req_text_last;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [LINE_BITS-1:0]     rsp_line_start;
   logic [LINE_BITS-1:0]     rsp_line_length;
   logic                     rsp_line_indent;
   logic                     rsp_run_last;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_BITS-1:0]      csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   line_break_scoreboard sb = new();
   bit hold_request = 1'b0;

   greedy_word_wrap_line_breaker i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_char_advance (req_char_advance),
      .req_text_last    (req_text_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_start   (rsp_line_start),
      .rsp_line_length  (rsp_line_length),
      .rsp_line_indent  (rsp_line_indent),
      .rsp_run_last     (rsp_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_line(rsp_line_start, rsp_line_length, rsp_line_indent, rsp_run_last);
   end

   // Receiver: stall pattern that changes mode now and then, plus one long hold on request.
   initial begin
      int mode;
      int mode_left;
      rsp_stall = 1'b0;
      mode = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            unique case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 1);
               default: rsp_stall <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("greedy_word_wrap_line_breaker_tb: done, errors");
      $finish;
   end

   task automatic send_char(input logic [15:0] code, input logic [7:0] adv, input logic last);
      @(negedge clock);
      req_valid <= 1'b1;
      req_char_code <= code;
      req_char_advance <= adv;
      req_text_last <= last;
      do @(posedge clock); while (req_stall);
      sb.note_char(code, adv, last);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops the sender and waits until every predicted line record has come out.
   task automatic drain_lines(input int settle);
      pause_sender(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic void pick_char(output logic [15:0] code, output logic [7:0] adv);
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)      code = 16'($urandom_range(16'h61, 16'h7A));
      else if (r < 70) code = CH_SPACE;
      else if (r < 75) code = CH_HYPHEN;
      else if (r < 80) code = CH_NEWLINE;
      else if (r < 85) code = ($urandom_range(0, 2) == 0) ? CH_TAB :
                              ($urandom_range(0, 1) == 0) ? CH_VTAB : CH_FORMFEED;
      else if (r < 89) code = ($urandom_range(0, 1) == 0) ? CH_IDEO_SP : CH_NBSP;
      else             code = 16'($urandom);
      r = $urandom_range(0, 99);
      if (r < 80)      adv = 8'($urandom_range(1, 20));
      else if (r < 88) adv = 8'd0;
      else if (r < 94) adv = 8'd255;
      else             adv = 8'($urandom);
   endfunction

   initial begin
      logic [15:0] code;
      logic [7:0]  adv;
      logic [15:0] width_px;
      logic [7:0]  gap;
      logic        wrap;
      logic        indent;
      logic [9:0]  indent_w;
      int          burst_left;
      bit          gappy;

      reset = 1'b1;
      req_valid = 1'b0;
      req_char_code = '0;
      req_char_advance = '0;
      req_text_last = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Narrow line of three ten-pixel characters, indent on.
      write_csr(CSR_MAX_LINE_WIDTH, 16'd30);
      write_csr(CSR_CHAR_GAP, 16'd2);
      write_csr(CSR_WRAP_WORDS, 16'd1);
      write_csr(CSR_INDENT_ENABLE, 16'd1);
      write_csr(CSR_INDENT_WIDTH, 16'd5);

      send_char(16'h61, 8'd8, 1'b0);
      send_char(16'h62, 8'd8, 1'b0);
      send_char(CH_SPACE, 8'd8, 1'b0);
      send_char(16'h63, 8'd8, 1'b0);          // word moves down
      send_char(CH_NEWLINE, 8'd8, 1'b0);
      send_char(16'h64, 8'd8, 1'b0);          // indented paragraph start
      send_char(CH_SPACE, 8'd8, 1'b0);
      send_char(CH_SPACE, 8'd8, 1'b0);        // overflowing space starts swallowing
      send_char(CH_TAB, 8'd8, 1'b0);
      send_char(CH_NEWLINE, 8'd8, 1'b0);      // newline while swallowing
      send_char(CH_IDEO_SP, 8'd8, 1'b0);      // no indent after this one
      send_char(16'h65, 8'd8, 1'b0);
      send_char(CH_HYPHEN, 8'd8, 1'b0);
      send_char(CH_HYPHEN, 8'd8, 1'b0);       // overflowing hyphen
      send_char(16'h66, 8'd8, 1'b0);
      send_char(CH_SPACE, 8'd8, 1'b0);
      send_char(16'h67, 8'd8, 1'b0);
      send_char(16'h68, 8'd28, 1'b0);         // word too wide after the move
      send_char(CH_NBSP, 8'd0, 1'b0);
      send_char(16'hFFFF, 8'd255, 1'b0);
      send_char(CH_SPACE, 8'd8, 1'b0);
      send_char(CH_SPACE, 8'd8, 1'b0);
      send_char(CH_VTAB, 8'd8, 1'b0);
      send_char(CH_FORMFEED, 8'd8, 1'b1);     // text ends while swallowing
      drain_lines(4);

      for (int phase = 0; phase < 8; phase++) begin
         unique case (phase)
            0: begin
               width_px = 16'd0; gap = 8'd0; wrap = 1'b1; indent = 1'b1; indent_w = 10'd1023;
            end
            1: begin
               width_px = 16'hFFFF; gap = 8'd255; wrap = 1'b0; indent = 1'b0; indent_w = 10'd0;
            end
            2: begin
               width_px = 16'($urandom_range(20, 160)); gap = 8'($urandom_range(0, 6));
               wrap = 1'b1; indent = 1'b1; indent_w = 10'($urandom_range(0, 40));
            end
            3: begin
               // Every character overflows, so each one yields a record.
               width_px = 16'd1; gap = 8'd3; wrap = 1'b0; indent = 1'b0;
               indent_w = 10'($urandom);
            end
            default: begin
               width_px = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(16, 200));
               gap = 8'($urandom_range(0, 8));
               wrap = 1'($urandom_range(0, 1));
               indent = 1'($urandom_range(0, 1));
               indent_w = 10'($urandom);
            end
         endcase
         write_csr(CSR_MAX_LINE_WIDTH, width_px);
         write_csr(CSR_CHAR_GAP, {8'($urandom), gap});
         write_csr(CSR_WRAP_WORDS, {15'($urandom), wrap});
         write_csr(CSR_INDENT_ENABLE, {15'($urandom), indent});
         write_csr(CSR_INDENT_WIDTH, {6'($urandom), indent_w});

         gappy = (phase != 3) && ($urandom_range(0, 2) != 0);
         if (phase == 3)
            hold_request = 1'b1;
         burst_left = $urandom_range(1, 8);
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            pick_char(code, adv);
            send_char(code, adv, $urandom_range(0, 14) == 0);
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 8);
               if (gappy)
                  pause_sender($urandom_range(1, 6));
            end
         end
         drain_lines(4);
      end

      repeat (10) @(posedge clock);
      if (sb.error_count == 0)
         $display("greedy_word_wrap_line_breaker_tb: done, clean");
      else
         $display("greedy_word_wrap_line_breaker_tb: done, errors");
      $finish;
   end

endmodule
